@@ hdl/assert_macros.svh @@
// Assertion macros used by the palette decoder back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PLUTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define PLUTD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ hdl/plutd_pkg.sv @@
// Types, constants and register codes of the palette decoder.
`timescale 1ns / 1ps
package plutd_pkg;

    // Field widths
    localparam int CMD_W      = 1;
    localparam int TADDR_W    = 12;
    localparam int VALUE_W    = 64;
    localparam int BYTE_W     = 8;
    localparam int CHAN_W     = 12;
    localparam int WIDTH_W    = 3;
    localparam int CHCOUNT_W  = 13;
    localparam int STRIDE_W   = 13;
    localparam int ELEM_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Bit buffer of the unpacker and its fill count
    localparam int BUF_W = 14;
    localparam int CNT_W = 4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Defaults of the top level parameters
    localparam int DEF_TABLE_DEPTH    = 4096;
    localparam int DEF_MAX_INDEX_BITS = 7;
    localparam int DEF_COUNT_BITS     = 24;

    // Register reset values
    localparam logic [WIDTH_W-1:0]   RST_INDEX_WIDTH   = 3'd4;
    localparam logic [CHCOUNT_W-1:0] RST_CHANNEL_COUNT = 13'd1;
    localparam logic [ELEM_W-1:0]    RST_PER_CHANNEL   = 24'd1;
    localparam logic                 RST_INTERLEAVED   = 1'b0;
    localparam logic [STRIDE_W-1:0]  RST_TABLE_STRIDE  = 13'd16;
    localparam logic [ELEM_W-1:0]    RST_ELEMENT_COUNT = 24'd1;

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 1'b0,
        CMD_BYTE = 1'b1
    } cmd_e_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INDEX_WIDTH   = 3'd0,
        CFG_CHANNEL_COUNT = 3'd1,
        CFG_PER_CHANNEL   = 3'd2,
        CFG_INTERLEAVED   = 3'd3,
        CFG_TABLE_STRIDE  = 3'd4,
        CFG_ELEMENT_COUNT = 3'd5
    } cfg_index_t;

    // Register file contents
    typedef struct packed {
        logic [WIDTH_W-1:0]   index_width;
        logic [CHCOUNT_W-1:0] channel_count;
        logic [ELEM_W-1:0]    per_channel_elements;
        logic                 interleaved_channels;
        logic [STRIDE_W-1:0]  table_stride;
        logic [ELEM_W-1:0]    element_count;
    } cfg_t;

    // Register write event as seen on the port
    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // One queued input item
    typedef struct packed {
        cmd_e_t              command;
        logic [TADDR_W-1:0]  table_address;
        logic [VALUE_W-1:0]  table_value;
        logic [BYTE_W-1:0]   packed_byte;
    } entry_t;

endpackage

@@ hdl/plutd_ifs.sv @@
// Handshake channels of the palette decoder: input items, results, register writes.
`timescale 1ns / 1ps

interface plutd_in_if;
    logic                              valid;
    logic                              ready;
    logic [plutd_pkg::CMD_W-1:0]       command;
    logic [plutd_pkg::TADDR_W-1:0]     table_address;
    logic [plutd_pkg::VALUE_W-1:0]     table_value;
    logic [plutd_pkg::BYTE_W-1:0]      packed_byte;

    modport source (output valid, command, table_address, table_value, packed_byte,
                    input ready);
    modport sink   (input valid, command, table_address, table_value, packed_byte,
                    output ready);
endinterface

interface plutd_out_if;
    logic                              valid;
    logic                              ready;
    logic [plutd_pkg::VALUE_W-1:0]     decoded_value;
    logic [plutd_pkg::CHAN_W-1:0]      channel_index;
    logic                              tensor_last;

    modport source (output valid, decoded_value, channel_index, tensor_last,
                    input ready);
    modport sink   (input valid, decoded_value, channel_index, tensor_last,
                    output ready);
endinterface

interface plutd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [plutd_pkg::CFG_IDX_W-1:0]   index;
    logic [plutd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/plutd_cfg.sv @@
// Configuration register file of the palette decoder.
`timescale 1ns / 1ps
module plutd_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    plutd_cfg_if.sink          cfg,
    output plutd_pkg::cfg_t    regs,
    output plutd_pkg::cfg_wr_t wr
);

    plutd_pkg::cfg_t regs_reg;
    plutd_pkg::cfg_t regs_next;

    // Take every write at once
    assign cfg.ready = 1'b1;

    // Publish the write event so the back end can react in the same cycle
    always_comb
    begin
        wr.valid = cfg.valid;
        wr.index = cfg.index;
        wr.data  = cfg.data;
    end

    // Decode the register index, ignore indexes beyond the list
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                plutd_pkg::CFG_INDEX_WIDTH:
                    regs_next.index_width = cfg.data[plutd_pkg::WIDTH_W-1:0];
                plutd_pkg::CFG_CHANNEL_COUNT:
                    regs_next.channel_count = cfg.data[plutd_pkg::CHCOUNT_W-1:0];
                plutd_pkg::CFG_PER_CHANNEL:
                    regs_next.per_channel_elements = cfg.data[plutd_pkg::ELEM_W-1:0];
                plutd_pkg::CFG_INTERLEAVED:
                    regs_next.interleaved_channels = cfg.data[0];
                plutd_pkg::CFG_TABLE_STRIDE:
                    regs_next.table_stride = cfg.data[plutd_pkg::STRIDE_W-1:0];
                plutd_pkg::CFG_ELEMENT_COUNT:
                    regs_next.element_count = cfg.data[plutd_pkg::ELEM_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.index_width          <= plutd_pkg::RST_INDEX_WIDTH;
            regs_reg.channel_count        <= plutd_pkg::RST_CHANNEL_COUNT;
            regs_reg.per_channel_elements <= plutd_pkg::RST_PER_CHANNEL;
            regs_reg.interleaved_channels <= plutd_pkg::RST_INTERLEAVED;
            regs_reg.table_stride         <= plutd_pkg::RST_TABLE_STRIDE;
            regs_reg.element_count        <= plutd_pkg::RST_ELEMENT_COUNT;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

@@ hdl/plutd_front.sv @@
// Front end: accepts input items, tags them by command and queues them for the back end.
`timescale 1ns / 1ps
module plutd_front
(
    input  logic              clk,
    input  logic              rst_n,
    plutd_in_if.sink          items,
    output logic              head_valid,
    output plutd_pkg::entry_t head,
    input  logic              head_pop
);

    localparam int PTR_W = $clog2(plutd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(plutd_pkg::QUEUE_DEPTH + 1);

    plutd_pkg::entry_t slot_reg [plutd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic              push;
    logic              pop;
    plutd_pkg::entry_t incoming;

    // Accept while a slot is free
    assign items.ready = (fill_reg != CNT_W'(plutd_pkg::QUEUE_DEPTH));
    assign push        = items.valid && items.ready;
    assign pop         = head_pop && head_valid;

    // Classify the item by its command bit
    always_comb
    begin
        incoming.command       = (items.command == plutd_pkg::CMD_BYTE) ?
                                 plutd_pkg::CMD_BYTE : plutd_pkg::CMD_LOAD;
        incoming.table_address = items.table_address;
        incoming.table_value   = items.table_value;
        incoming.packed_byte   = items.packed_byte;
    end

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(plutd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(plutd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the item payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

    assign head_valid = (fill_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

endmodule

@@ hdl/plutd_back.sv @@
// Back end: table writes, index unpacking, table reads and the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plutd_back
#(
    parameter int TABLE_DEPTH    = plutd_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_INDEX_BITS = plutd_pkg::DEF_MAX_INDEX_BITS,
    parameter int COUNT_BITS     = plutd_pkg::DEF_COUNT_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  plutd_pkg::cfg_t    cfg,
    input  plutd_pkg::cfg_wr_t cfg_wr,
    input  logic               head_valid,
    input  plutd_pkg::entry_t  head,
    output logic               head_pop,
    plutd_out_if.source        results
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int IW    = MAX_INDEX_BITS;
    localparam int CMPW  = ((COUNT_BITS > plutd_pkg::ELEM_W) ?
                            COUNT_BITS : plutd_pkg::ELEM_W) + 1;
    localparam int PRODW = plutd_pkg::CHAN_W + plutd_pkg::STRIDE_W;
    localparam int BSUMW = AW + plutd_pkg::STRIDE_W;

    // Value table
    logic [plutd_pkg::VALUE_W-1:0] table_mem [TABLE_DEPTH];

    // Unpacker and tensor position state
    logic [plutd_pkg::BUF_W-1:0]  buf_reg,    buf_next;
    logic [plutd_pkg::CNT_W-1:0]  cnt_reg,    cnt_next;
    logic                         loaded_reg, loaded_next;
    logic [plutd_pkg::CHAN_W-1:0] ch_reg,     ch_next;
    logic [AW-1:0]                base_reg,   base_next;
    logic [COUNT_BITS-1:0]        eic_reg,    eic_next;
    logic [COUNT_BITS-1:0]        done_reg,   done_next;

    // Result register
    logic                          out_valid_reg, out_valid_next;
    logic [plutd_pkg::VALUE_W-1:0] rd_data_reg;
    logic [plutd_pkg::CHAN_W-1:0]  out_ch_reg;
    logic                          out_last_reg;

    logic                          cfg_busy;
    logic                          width_wr;
    logic                          stride_wr;
    logic [PRODW-1:0]              stride_prod;
    logic [PRODW-1:0]              base_chk;
    logic [plutd_pkg::WIDTH_W-1:0] w_eff;
    logic [plutd_pkg::CNT_W-1:0]   w_cnt;
    logic                          is_load;
    logic                          is_byte;
    logic                          advance;
    logic                          load_go;
    logic                          issue;
    logic [plutd_pkg::BUF_W-1:0]   cur_buf;
    logic [plutd_pkg::CNT_W-1:0]   cur_cnt;
    logic [plutd_pkg::CNT_W-1:0]   rem_cnt;
    logic [plutd_pkg::BUF_W-1:0]   keep_mask;
    logic [IW-1:0]                 idx_mask;
    logic [IW-1:0]                 idx;
    logic [AW:0]                   addr_sum;
    logic [AW-1:0]                 rd_addr;
    logic [BSUMW-1:0]              base_sum;
    logic [CMPW-1:0]               done_plus;
    logic [CMPW-1:0]               eic_plus;
    logic                          last;
    logic [plutd_pkg::CHAN_W-1:0]  ch_inc;
    logic [plutd_pkg::CHAN_W-1:0]  ch_adv;
    logic [AW-1:0]                 base_adv;

    // Register writes stall the back end for that cycle
    assign cfg_busy  = cfg_wr.valid;
    assign width_wr  = cfg_wr.valid && (cfg_wr.index == plutd_pkg::CFG_INDEX_WIDTH);
    assign stride_wr = cfg_wr.valid && (cfg_wr.index == plutd_pkg::CFG_TABLE_STRIDE);
    assign stride_prod = PRODW'(ch_reg) * PRODW'(cfg_wr.data[plutd_pkg::STRIDE_W-1:0]);
    assign base_chk    = PRODW'(ch_reg) * PRODW'(cfg.table_stride);

    // Clamp the index width
    assign w_eff = (cfg.index_width > plutd_pkg::WIDTH_W'(MAX_INDEX_BITS)) ?
                   plutd_pkg::WIDTH_W'(MAX_INDEX_BITS) : cfg.index_width;
    assign w_cnt = plutd_pkg::CNT_W'(w_eff);

    assign is_load = head_valid && (head.command == plutd_pkg::CMD_LOAD);
    assign is_byte = head_valid && (head.command == plutd_pkg::CMD_BYTE);
    assign advance = !out_valid_reg || results.ready;
    assign load_go = is_load && !cfg_busy;
    assign issue   = is_byte && (w_eff != '0) && advance && !cfg_busy;

    // Merge a fresh byte below the buffered bits and cut out the next index
    always_comb
    begin
        cur_buf   = loaded_reg ? buf_reg :
                    plutd_pkg::BUF_W'({buf_reg, head.packed_byte});
        cur_cnt   = loaded_reg ? cnt_reg : cnt_reg + plutd_pkg::CNT_W'(8);
        rem_cnt   = cur_cnt - w_cnt;
        idx_mask  = IW'((plutd_pkg::BUF_W'(1) << w_eff) - plutd_pkg::BUF_W'(1));
        idx       = IW'(cur_buf >> rem_cnt) & idx_mask;
        keep_mask = (plutd_pkg::BUF_W'(1) << rem_cnt) - plutd_pkg::BUF_W'(1);
        addr_sum  = (AW+1)'(base_reg) + (AW+1)'(idx);
        rd_addr   = addr_sum[AW-1:0];
    end

    // Tensor position: last flag and channel step
    always_comb
    begin
        done_plus = CMPW'(done_reg) + CMPW'(1);
        eic_plus  = CMPW'(eic_reg) + CMPW'(1);
        last      = (done_plus >= CMPW'(cfg.element_count));
        ch_inc    = ch_reg + plutd_pkg::CHAN_W'(1);
        base_sum  = BSUMW'(base_reg) + BSUMW'(cfg.table_stride);
        if (({1'b0, ch_inc} >= cfg.channel_count) || (ch_inc == '0))
        begin
            ch_adv   = '0;
            base_adv = '0;
        end
        else
        begin
            ch_adv   = ch_inc;
            base_adv = base_sum[AW-1:0];
        end
    end

    // Step the unpacker one index per cycle unless the output or a write stalls
    always_comb
    begin
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        loaded_next = loaded_reg;
        ch_next     = ch_reg;
        base_next   = base_reg;
        eic_next    = eic_reg;
        done_next   = done_reg;
        head_pop    = 1'b0;

        if (load_go)
        begin
            head_pop = 1'b1;
        end
        else if (is_byte && (w_eff == '0) && !cfg_busy)
        begin
            // drop the byte without touching the buffer
            head_pop = 1'b1;
        end
        else if (issue)
        begin
            if (last)
            begin
                buf_next    = '0;
                cnt_next    = '0;
                loaded_next = 1'b0;
                ch_next     = '0;
                base_next   = '0;
                eic_next    = '0;
                done_next   = '0;
                head_pop    = 1'b1;
            end
            else
            begin
                buf_next  = cur_buf & keep_mask;
                cnt_next  = rem_cnt;
                done_next = COUNT_BITS'(done_plus);
                if (cfg.interleaved_channels)
                begin
                    ch_next   = ch_adv;
                    base_next = base_adv;
                end
                else if (eic_plus >= CMPW'(cfg.per_channel_elements))
                begin
                    eic_next  = '0;
                    ch_next   = ch_adv;
                    base_next = base_adv;
                end
                else
                begin
                    eic_next = COUNT_BITS'(eic_plus);
                end
                if (rem_cnt < w_cnt)
                begin
                    loaded_next = 1'b0;
                    head_pop    = 1'b1;
                end
                else
                begin
                    loaded_next = 1'b1;
                end
            end
        end

        // Width change drops buffered bits, stride change rebuilds the table base
        if (width_wr)
        begin
            buf_next    = '0;
            cnt_next    = '0;
            loaded_next = 1'b0;
        end
        if (stride_wr)
        begin
            base_next = stride_prod[AW-1:0];
        end
    end

    // Result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            cnt_reg       <= '0;
            loaded_reg    <= 1'b0;
            ch_reg        <= '0;
            base_reg      <= '0;
            eic_reg       <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            loaded_reg    <= loaded_next;
            ch_reg        <= ch_next;
            base_reg      <= base_next;
            eic_reg       <= eic_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Table: one write port for loads, one registered read port for indices
    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            table_mem[AW'(head.table_address)] <= head.table_value;
        end
        if (issue)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // Capture result side fields with the read
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            out_ch_reg   <= ch_reg;
            out_last_reg <= last;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.decoded_value = rd_data_reg;
    assign results.channel_index = out_ch_reg;
    assign results.tensor_last   = out_last_reg;

    // A partly consumed byte must still be at the head of the queue
    `PLUTD_ASSERT(a_loaded_head, clk, rst_n,
        loaded_reg |-> (head_valid && (head.command == plutd_pkg::CMD_BYTE)),
        "unpacker holds a byte that left the queue")
    // The final element returns the tensor position to its start
    `PLUTD_ASSERT(a_last_clears, clk, rst_n,
        (issue && last) |=> ((done_reg == '0) && (ch_reg == '0) && !loaded_reg),
        "tensor position not cleared after last element")
    // The running table base tracks channel times stride
    `PLUTD_ASSERT(a_base_track, clk, rst_n,
        base_reg == base_chk[AW-1:0],
        "table base out of step with channel")

endmodule

@@ hdl/packed_index_lut_decoder_core.sv @@
// Top level of the palette decoder: register file, front queue and back end.
`timescale 1ns / 1ps
// Decodes a stream of packed table indices into 64-bit table entries. A load item
// writes one table word. A stream byte yields floor((leftover + 8) / width) indices,
// eight at a width of one and one or two at a width of seven, fewer when the tensor
// ends; the single table read port serves one index per cycle while the result
// register has room and no register write is under way. A byte when the width is
// zero is dropped. The input side accepts an item per cycle while the two-entry queue
// has room; a byte is queued, and its first result is registered when the back end
// reads the table for it. Register writes are taken at once and hold the back end for
// that cycle. Table addresses wrap modulo the table depth, which must be a power of two.
module packed_index_lut_decoder_core
#(
    parameter int TABLE_DEPTH    = plutd_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_INDEX_BITS = plutd_pkg::DEF_MAX_INDEX_BITS,
    parameter int COUNT_BITS     = plutd_pkg::DEF_COUNT_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    plutd_cfg_if.sink   cfg,
    plutd_in_if.sink    items,
    plutd_out_if.source results
);

    plutd_pkg::cfg_t    regs;
    plutd_pkg::cfg_wr_t wr;
    logic               head_valid;
    plutd_pkg::entry_t  head;
    logic               head_pop;

    // Hold configuration registers
    plutd_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs),
        .wr    (wr)
    );

    // Accept and queue items
    plutd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    // Carry out loads and decode indices
    plutd_back
    #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .COUNT_BITS     (COUNT_BITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (regs),
        .cfg_wr     (wr),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .results    (results)
    );

endmodule

@@ bench/tb_packed_index_lut_decoder_core.sv @@
// Self-checking testbench for the palette decoder: directed rows, then random configuration phases.
`timescale 1ns / 1ps
module tb_packed_index_lut_decoder_core;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int LUT_DEPTH    = plutd_pkg::DEF_TABLE_DEPTH;
    localparam int MAX_GAP      = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 16;
    // Input items to aim for over the whole run, directed ones included
    localparam int ITEM_TARGET  = 110;
    localparam int PRESSURE_PH  = 1;
    localparam int MUTE_PH      = 3;
    // Register index with no register behind it
    localparam logic [plutd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_BYTE
    } row_kind_t;

    // One directed row: register write, table load or stream byte
    typedef struct {
        row_kind_t                            kind;
        logic [plutd_pkg::CFG_IDX_W-1:0]      reg_idx;
        logic [plutd_pkg::TADDR_W-1:0]        addr;
        logic [plutd_pkg::VALUE_W-1:0]        arg;
        bit                                   typed;
        logic [plutd_pkg::VALUE_W-1:0]        exp_value;
        logic                                 exp_last;
    } row_t;

    // Unpacker position within the stream and the tensor
    typedef struct {
        logic [plutd_pkg::BUF_W-1:0]  bits;
        logic [plutd_pkg::CNT_W-1:0]  nbits;
        logic [plutd_pkg::CHAN_W-1:0] chan;
        logic [plutd_pkg::ELEM_W-1:0] in_chan;
        logic [plutd_pkg::ELEM_W-1:0] done;
    } unpack_state_t;

    // One decoded element, with the table address it came from
    typedef struct {
        logic [plutd_pkg::VALUE_W-1:0] value;
        logic [plutd_pkg::CHAN_W-1:0]  chan;
        logic                          last;
        logic [plutd_pkg::TADDR_W-1:0] addr;
    } element_t;

    logic clk = 1'b0;
    logic rst_n;

    plutd_cfg_if cfg_bus ();
    plutd_in_if  in_bus ();
    plutd_out_if out_bus ();

    packed_index_lut_decoder_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .items   (in_bus),
        .results (out_bus)
    );

    // Shadow of the block: table, registers, unpacker
    logic [plutd_pkg::VALUE_W-1:0] lut [LUT_DEPTH];
    bit                            lut_written [LUT_DEPTH];
    plutd_pkg::cfg_t               regs;
    unpack_state_t                 unpack;
    element_t                      due_elements[$];

    int  errors           = 0;
    int  items_taken      = 0;
    int  elements_checked = 0;
    int  reg_writes       = 0;
    int  holds_done       = 0;
    int  cycles           = 0;
    bit  send_steady      = 1'b0;
    bit  recv_steady      = 1'b0;
    bit  hold_off_req     = 1'b0;

    always #10 clk = ~clk;

    // Step the channel counter, wrapping at the channel count
    function automatic logic [plutd_pkg::CHAN_W-1:0] next_channel(
        input logic [plutd_pkg::CHAN_W-1:0] chan);
        logic [plutd_pkg::CHAN_W-1:0] nxt;
        nxt = chan + 1'b1;
        return (32'(nxt) >= 32'(regs.channel_count)) ? '0 : nxt;
    endfunction

    // Decode one stream byte against the current registers and table
    function automatic void decode_byte(input unpack_state_t cur,
                                        input logic [plutd_pkg::BYTE_W-1:0] b,
                                        output unpack_state_t nxt, output element_t elems[$]);
        int unsigned w;
        int unsigned buffer;
        int unsigned count;
        int unsigned idx;
        element_t    e;
        elems = {};
        nxt   = cur;
        w     = regs.index_width;
        if (w > plutd_pkg::DEF_MAX_INDEX_BITS)
            w = plutd_pkg::DEF_MAX_INDEX_BITS;
        if (w == 0)
            return;
        buffer = ((32'(cur.bits) << 8) | 32'(b)) & ((1 << plutd_pkg::BUF_W) - 1);
        count  = 32'(cur.nbits) + 8;
        while (count >= w && elems.size() < 8)
        begin
            count  -= w;
            idx     = (buffer >> count) & ((1 << w) - 1);
            buffer &= (1 << count) - 1;
            e.addr  = plutd_pkg::TADDR_W'((32'(nxt.chan) * 32'(regs.table_stride) + idx)
                                          % LUT_DEPTH);
            e.value = lut[e.addr];
            e.chan  = nxt.chan;
            e.last  = (32'(nxt.done) + 1 >= 32'(regs.element_count));
            elems.push_back(e);
            // Last element of the tensor: drop leftover bits, restart counters
            if (e.last)
            begin
                nxt = '{default: '0};
                return;
            end
            nxt.done = nxt.done + 1'b1;
            if (regs.interleaved_channels)
            begin
                nxt.chan = next_channel(nxt.chan);
            end
            else if (32'(nxt.in_chan) + 1 >= 32'(regs.per_channel_elements))
            begin
                nxt.in_chan = '0;
                nxt.chan    = next_channel(nxt.chan);
            end
            else
            begin
                nxt.in_chan = nxt.in_chan + 1'b1;
            end
        end
        nxt.bits  = plutd_pkg::BUF_W'(buffer);
        nxt.nbits = plutd_pkg::CNT_W'(count);
    endfunction

    // Offer one item, after a random gap unless sending steadily, and hold it until taken
    task automatic offer_item(input plutd_pkg::cmd_e_t cmd,
                              input logic [plutd_pkg::TADDR_W-1:0] addr,
                              input logic [plutd_pkg::VALUE_W-1:0] value,
                              input logic [plutd_pkg::BYTE_W-1:0] b);
        int gap;
        gap = send_steady ? 0 : $urandom_range(MAX_GAP, 0);
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.command       <= cmd;
        in_bus.table_address <= addr;
        in_bus.table_value   <= value;
        in_bus.packed_byte   <= b;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        items_taken++;
    endtask

    task automatic load_entry(input logic [plutd_pkg::TADDR_W-1:0] addr,
                              input logic [plutd_pkg::VALUE_W-1:0] value);
        offer_item(plutd_pkg::CMD_LOAD, addr, value, plutd_pkg::BYTE_W'($urandom));
        lut[addr]         = value;
        lut_written[addr] = 1'b1;
    endtask

    // Send a stream byte; fill any table entry it would read that was never loaded
    task automatic send_byte(input logic [plutd_pkg::BYTE_W-1:0] b, input bit typed,
                             input logic [plutd_pkg::VALUE_W-1:0] exp_value,
                             input logic exp_last);
        unpack_state_t nxt;
        element_t      elems[$];
        element_t      e;
        decode_byte(unpack, b, nxt, elems);
        foreach (elems[k])
            if (!lut_written[elems[k].addr])
                load_entry(elems[k].addr, {$urandom, $urandom});
        decode_byte(unpack, b, nxt, elems);
        if (typed)
        begin
            e.value = exp_value;
            e.chan  = '0;
            e.last  = exp_last;
            e.addr  = '0;
            elems   = {e};
        end
        offer_item(plutd_pkg::CMD_BYTE, plutd_pkg::TADDR_W'($urandom),
                   {$urandom, $urandom}, b);
        unpack = nxt;
        foreach (elems[k])
            due_elements.push_back(elems[k]);
    endtask

    // Drop input valid, wait for every expected result, then let the back end go quiet
    task automatic settle_block();
        in_bus.valid <= 1'b0;
        while (due_elements.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write one register; the caller lowers valid after the last write of a group
    task automatic write_reg(input logic [plutd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [plutd_pkg::CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        reg_writes++;
        case (idx)
            plutd_pkg::CFG_INDEX_WIDTH:
            begin
                regs.index_width = data[plutd_pkg::WIDTH_W-1:0];
                unpack.bits      = '0;
                unpack.nbits     = '0;
            end
            plutd_pkg::CFG_CHANNEL_COUNT:
                regs.channel_count = data[plutd_pkg::CHCOUNT_W-1:0];
            plutd_pkg::CFG_PER_CHANNEL:
                regs.per_channel_elements = data[plutd_pkg::ELEM_W-1:0];
            plutd_pkg::CFG_INTERLEAVED:
                regs.interleaved_channels = data[0];
            plutd_pkg::CFG_TABLE_STRIDE:
                regs.table_stride = data[plutd_pkg::STRIDE_W-1:0];
            plutd_pkg::CFG_ELEMENT_COUNT:
                regs.element_count = data[plutd_pkg::ELEM_W-1:0];
            default: ;
        endcase
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        out_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall        = HOLD_CYCLES;
                holds_done++;
            end
            else
            begin
                stall = recv_steady ? 0 : $urandom_range(MAX_GAP, 0);
            end
            if (stall > 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge clk);
            while (!out_bus.valid) @(posedge clk);
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        element_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (due_elements.size() == 0)
            begin
                $error("unexpected result: decoded_value %h channel_index %0d tensor_last %0b",
                       out_bus.decoded_value, out_bus.channel_index, out_bus.tensor_last);
                errors++;
            end
            else
            begin
                want = due_elements.pop_front();
                elements_checked++;
                if (out_bus.decoded_value !== want.value)
                begin
                    $error("decoded_value: expected %h, got %h", want.value,
                           out_bus.decoded_value);
                    errors++;
                end
                if (out_bus.channel_index !== want.chan)
                begin
                    $error("channel_index: expected %0d, got %0d", want.chan,
                           out_bus.channel_index);
                    errors++;
                end
                if (out_bus.tensor_last !== want.last)
                begin
                    $error("tensor_last: expected %0b, got %0b", want.last,
                           out_bus.tensor_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     due_elements.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        row_t                             dir_rows[$];
        row_t                             r;
        int                               phase;
        int                               batch;
        logic [plutd_pkg::CFG_DATA_W-1:0] w_val;
        logic [plutd_pkg::CFG_DATA_W-1:0] cc_val;
        logic [plutd_pkg::CFG_DATA_W-1:0] pce_val;
        logic [plutd_pkg::CFG_DATA_W-1:0] stride_val;
        logic [plutd_pkg::CFG_DATA_W-1:0] ec_val;

        // Known values on every input from time zero
        rst_n                 = 1'b0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= '0;
        cfg_bus.data         <= '0;
        in_bus.valid         <= 1'b0;
        in_bus.command       <= plutd_pkg::CMD_LOAD;
        in_bus.table_address <= '0;
        in_bus.table_value   <= '0;
        in_bus.packed_byte   <= '0;

        foreach (lut[i])
        begin
            lut[i]         = '0;
            lut_written[i] = 1'b0;
        end
        regs.index_width          = plutd_pkg::RST_INDEX_WIDTH;
        regs.channel_count        = plutd_pkg::RST_CHANNEL_COUNT;
        regs.per_channel_elements = plutd_pkg::RST_PER_CHANNEL;
        regs.interleaved_channels = plutd_pkg::RST_INTERLEAVED;
        regs.table_stride         = plutd_pkg::RST_TABLE_STRIDE;
        regs.element_count        = plutd_pkg::RST_ELEMENT_COUNT;
        unpack                    = '{default: '0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: width 4, one channel, stride 16, one-element tensor
        dir_rows.push_back('{ROW_LOAD, CFG_SPARE, 12'd10, {64{1'b1}}, 1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_LOAD, CFG_SPARE, 12'd0, 64'd0, 1'b0, '0, 1'b0});
        // Index ten; the low nibble is dropped after the last element
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'hA5, 1'b1, {64{1'b1}}, 1'b1});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'h0F, 1'b1, 64'd0, 1'b1});
        dir_rows.push_back('{ROW_LOAD, CFG_SPARE, 12'd4095, 64'h8000_0000_0000_0001,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_LOAD, CFG_SPARE, 12'd1, 64'h0123_4567_89AB_CDEF,
                             1'b0, '0, 1'b0});
        // Width one with a zero element count: every result is the last one
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_INDEX_WIDTH, '0, 64'd1,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_ELEMENT_COUNT, '0, 64'd0,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'h80, 1'b1,
                             64'h0123_4567_89AB_CDEF, 1'b1});
        // Interleaved channels, stride that wraps the table
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_ELEMENT_COUNT, '0, 64'd20,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_INTERLEAVED, '0, 64'd1,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_CHANNEL_COUNT, '0, 64'd3,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_TABLE_STRIDE, '0, 64'd4095,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'hFF, 1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'h00, 1'b0, '0, 1'b0});
        // Widest index across byte borders; zero per-channel and channel counts
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_INDEX_WIDTH, '0, 64'd7,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_INTERLEAVED, '0, 64'd0,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_PER_CHANNEL, '0, 64'd0,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_CHANNEL_COUNT, '0, 64'd0,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_TABLE_STRIDE, '0, 64'd8191,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'hFE, 1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'h01, 1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'h7F, 1'b0, '0, 1'b0});
        // Channel count beyond the 12-bit counter
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_CHANNEL_COUNT, '0, 64'd8191,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_PER_CHANNEL, '0, 64'd1,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'hC3, 1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'h3C, 1'b0, '0, 1'b0});
        // Zero width: the byte is ignored
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_INDEX_WIDTH, '0, 64'd0,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'hAA, 1'b0, '0, 1'b0});
        // Unused register index, then a width write with high data bits set
        dir_rows.push_back('{ROW_CFG, CFG_SPARE, '0, 64'hFF_FFFF, 1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_INDEX_WIDTH, '0, 64'hFF_FFFB,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'h5A, 1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'hA5, 1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'hFF, 1'b0, '0, 1'b0});
        // Largest element and per-channel counts, 4096 channels and a stride equal to the table depth
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_ELEMENT_COUNT, '0, 64'hFF_FFFF,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_PER_CHANNEL, '0, 64'hFF_FFFF,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_CHANNEL_COUNT, '0, 64'd4096,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_CFG, plutd_pkg::CFG_TABLE_STRIDE, '0, 64'd4096,
                             1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'h96, 1'b0, '0, 1'b0});
        dir_rows.push_back('{ROW_BYTE, CFG_SPARE, '0, 64'h69, 1'b0, '0, 1'b0});

        // Walk the directed rows
        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            case (r.kind)
                ROW_CFG:
                begin
                    settle_block();
                    write_reg(r.reg_idx, r.arg[plutd_pkg::CFG_DATA_W-1:0]);
                    cfg_bus.valid <= 1'b0;
                end
                ROW_LOAD: load_entry(r.addr, r.arg);
                default:  send_byte(r.arg[plutd_pkg::BYTE_W-1:0], r.typed, r.exp_value,
                                    r.exp_last);
            endcase
        end

        // Random phases, each under a fresh setting of every register
        phase = 0;
        while ((items_taken < ITEM_TARGET) || (phase <= MUTE_PH))
        begin
            settle_block();
            if (phase == PRESSURE_PH)
                w_val = 1;
            else if (phase == MUTE_PH)
                w_val = 0;
            else
                w_val = $urandom_range(7, 1);
            case ($urandom_range(5, 0))
                0:       cc_val = 0;
                1:       cc_val = 1;
                2:       cc_val = 4096;
                3:       cc_val = 8191;
                default: cc_val = $urandom_range(8, 2);
            endcase
            case ($urandom_range(4, 0))
                0:       pce_val = 0;
                1:       pce_val = 24'hFF_FFFF;
                default: pce_val = $urandom_range(6, 1);
            endcase
            case ($urandom_range(5, 0))
                0:       stride_val = 0;
                1:       stride_val = 1;
                2:       stride_val = 4095;
                3:       stride_val = 4096;
                4:       stride_val = 8191;
                default: stride_val = $urandom_range(64, 2);
            endcase
            case ($urandom_range(5, 0))
                0:       ec_val = 0;
                1:       ec_val = 24'hFF_FFFF;
                2:       ec_val = 1;
                default: ec_val = $urandom_range(40, 2);
            endcase
            if (phase == PRESSURE_PH)
                ec_val = 24'hFF_FFFF;
            write_reg(plutd_pkg::CFG_INDEX_WIDTH, w_val);
            write_reg(plutd_pkg::CFG_CHANNEL_COUNT, cc_val);
            write_reg(plutd_pkg::CFG_PER_CHANNEL, pce_val);
            write_reg(plutd_pkg::CFG_INTERLEAVED,
                      plutd_pkg::CFG_DATA_W'($urandom_range(1, 0)));
            write_reg(plutd_pkg::CFG_TABLE_STRIDE, stride_val);
            write_reg(plutd_pkg::CFG_ELEMENT_COUNT, ec_val);
            cfg_bus.valid <= 1'b0;

            // Pressure phase: results held back while items keep coming
            if (phase == PRESSURE_PH)
            begin
                send_steady  = 1'b1;
                recv_steady  = 1'b0;
                hold_off_req = 1'b1;
            end
            else
            begin
                send_steady = ($urandom_range(3, 0) == 0);
                recv_steady = ($urandom_range(3, 0) == 0);
            end

            batch = (phase == MUTE_PH) ? 4 : $urandom_range(20, 12);
            repeat (batch)
            begin
                if ($urandom_range(9, 0) < 2)
                    load_entry(plutd_pkg::TADDR_W'($urandom), {$urandom, $urandom});
                else
                    send_byte(plutd_pkg::BYTE_W'($urandom), 1'b0, '0, 1'b0);
            end
            phase++;
        end

        settle_block();
        send_steady = 1'b0;
        recv_steady = 1'b0;

        $display("run covered %0d input items and %0d checked results over %0d register writes",
                 items_taken, elements_checked, reg_writes);
        $display("random phases: %0d, including %0d output hold-off(s) of %0d cycles",
                 phase, holds_done, HOLD_CYCLES);
        if (errors == 0 && due_elements.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
